// ===== hdl/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and constants of the CSV stream tokenizer.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int POSITION_BITS = 32;
  localparam int MAX_RESULTS   = 3;
  localparam int FIFO_DEPTH    = 4;
  localparam int PTR_BITS      = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS      = $clog2(FIFO_DEPTH + 1);
  localparam int ADDR_BITS     = 4;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;

  localparam logic [7:0] DELIMITER_RESET = 8'd44;
  localparam logic [7:0] QUOTE_RESET     = 8'd34;

  localparam logic [1:0] REG_DELIMITER   = 2'd0;
  localparam logic [1:0] REG_QUOTE       = 2'd1;
  localparam logic [1:0] REG_QUOTE_EN    = 2'd2;
  localparam logic [1:0] REG_SKIP_HEADER = 2'd3;

  localparam logic ERR_AFTER_QUOTE = 1'b0;
  localparam logic ERR_UNCLOSED    = 1'b1;

  typedef enum logic [2:0] {
    KIND_CONTENT = 3'd0,
    KIND_FIELD   = 3'd1,
    KIND_ROW     = 3'd2,
    KIND_ERROR   = 3'd3,
    KIND_DONE    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    QM_OUTSIDE = 2'd0,
    QM_INSIDE  = 2'd1,
    QM_PENDING = 2'd2,
    QM_CLOSED  = 2'd3
  } quote_mode_t;

  typedef struct packed {
    logic [7:0] delimiter_char;
    logic [7:0] quote_char;
    logic       quote_enable;
    logic       skip_first_row;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    logic        error_code;
    logic [31:0] error_position;
    logic        last_result;
  } result_t;

endpackage

// ===== hdl/cst_parse.sv =====
// ----------------------------------------------------------------------------
// cst_parse
// Parse state and the single-pass next-state and result logic for one byte.
// ----------------------------------------------------------------------------
module cst_parse (
  input  logic                                        clk,
  input  logic                                        rst,
  input  cst_pkg::cfg_t                               cfg,
  input  logic                                        advance,
  input  logic [7:0]                                  in_byte,
  input  logic                                        end_of_source,
  output cst_pkg::result_t [cst_pkg::MAX_RESULTS-1:0] res,
  output logic [cst_pkg::MAX_RESULTS-1:0]             res_valid
);

  cst_pkg::quote_mode_t                quote_mode, quote_mode_next;
  logic                                field_started, field_started_next;
  logic                                row_has_fields, row_has_fields_next;
  logic                                skip_next_lf, skip_next_lf_next;
  logic                                header_done, header_done_next;
  logic                                error_seen, error_seen_next;
  logic [cst_pkg::POSITION_BITS-1:0]   byte_position, byte_position_next;
  logic [cst_pkg::POSITION_BITS-1:0]   pos_inc;

  cst_pkg::quote_mode_t qm_eff;
  logic                 is_ws;
  logic                 main_v, end_v;
  cst_pkg::kind_t       main_kind, end_kind;
  logic [7:0]           main_byte;
  logic                 main_code, end_code;
  logic [31:0]          main_pos, end_pos;

  assign pos_inc = byte_position + 1'b1;
  assign is_ws   = (in_byte == cst_pkg::CH_SP) || (in_byte == cst_pkg::CH_TAB) ||
                   (in_byte == cst_pkg::CH_VT) || (in_byte == cst_pkg::CH_FF);

  always_comb begin
    quote_mode_next     = quote_mode;
    field_started_next  = field_started;
    row_has_fields_next = row_has_fields;
    skip_next_lf_next   = skip_next_lf;
    header_done_next    = header_done;
    error_seen_next     = error_seen;
    byte_position_next  = pos_inc;
    qm_eff              = quote_mode;
    main_v              = 1'b0;
    main_kind           = cst_pkg::KIND_CONTENT;
    main_byte           = 8'd0;
    main_code           = cst_pkg::ERR_AFTER_QUOTE;
    main_pos            = 32'd0;
    end_v               = 1'b0;
    end_kind            = cst_pkg::KIND_ROW;
    end_code            = cst_pkg::ERR_AFTER_QUOTE;
    end_pos             = 32'd0;

    if (!error_seen) begin
      skip_next_lf_next = 1'b0;
      // LF right after CR is swallowed
      if (!(skip_next_lf && in_byte == cst_pkg::CH_LF)) begin
        if (quote_mode == cst_pkg::QM_INSIDE) begin
          field_started_next = 1'b1;
          if (in_byte == cfg.quote_char) begin
            quote_mode_next = cst_pkg::QM_PENDING;
          end else begin
            main_v    = 1'b1;
            main_kind = cst_pkg::KIND_CONTENT;
            main_byte = in_byte;
          end
        end else if (quote_mode == cst_pkg::QM_PENDING && in_byte == cfg.quote_char) begin
          // doubled quote is a literal quote
          main_v          = 1'b1;
          main_kind       = cst_pkg::KIND_CONTENT;
          main_byte       = in_byte;
          quote_mode_next = cst_pkg::QM_INSIDE;
        end else begin
          if (quote_mode == cst_pkg::QM_PENDING) begin
            qm_eff = cst_pkg::QM_CLOSED;
          end
          quote_mode_next = qm_eff;
          priority if (cfg.quote_enable && in_byte == cfg.quote_char && !field_started) begin
            quote_mode_next    = cst_pkg::QM_INSIDE;
            field_started_next = 1'b1;
          end else if (in_byte == cfg.delimiter_char) begin
            main_v              = 1'b1;
            main_kind           = cst_pkg::KIND_FIELD;
            field_started_next  = 1'b0;
            row_has_fields_next = 1'b1;
            quote_mode_next     = cst_pkg::QM_OUTSIDE;
          end else if (in_byte == cst_pkg::CH_LF || in_byte == cst_pkg::CH_CR) begin
            main_v              = 1'b1;
            main_kind           = cst_pkg::KIND_ROW;
            header_done_next    = 1'b1;
            field_started_next  = 1'b0;
            row_has_fields_next = 1'b0;
            quote_mode_next     = cst_pkg::QM_OUTSIDE;
            skip_next_lf_next   = (in_byte == cst_pkg::CH_CR);
          end else if (qm_eff == cst_pkg::QM_CLOSED) begin
            if (!is_ws) begin
              main_v          = 1'b1;
              main_kind       = cst_pkg::KIND_ERROR;
              main_code       = cst_pkg::ERR_AFTER_QUOTE;
              main_pos        = 32'(byte_position);
              error_seen_next = 1'b1;
            end
          end else begin
            main_v             = 1'b1;
            main_kind          = cst_pkg::KIND_CONTENT;
            main_byte          = in_byte;
            field_started_next = 1'b1;
            quote_mode_next    = cst_pkg::QM_OUTSIDE;
          end
        end
      end
    end

    // header rows: content, field end and row end are dropped
    if (main_v && main_kind != cst_pkg::KIND_ERROR && cfg.skip_first_row && !header_done) begin
      main_v = 1'b0;
    end

    if (end_of_source) begin
      if (!error_seen_next) begin
        if (quote_mode_next == cst_pkg::QM_INSIDE) begin
          end_v    = 1'b1;
          end_kind = cst_pkg::KIND_ERROR;
          end_code = cst_pkg::ERR_UNCLOSED;
          end_pos  = 32'(pos_inc);
        end else if (field_started_next || row_has_fields_next) begin
          end_v = !(cfg.skip_first_row && !header_done_next);
        end
      end
      quote_mode_next     = cst_pkg::QM_OUTSIDE;
      field_started_next  = 1'b0;
      row_has_fields_next = 1'b0;
      skip_next_lf_next   = 1'b0;
      header_done_next    = 1'b0;
      error_seen_next     = 1'b0;
      byte_position_next  = '0;
    end
  end

  always_comb begin
    res_valid = {end_of_source, end_v, main_v};

    res[0].kind           = main_kind;
    res[0].out_byte       = main_byte;
    res[0].error_code     = main_code;
    res[0].error_position = main_pos;
    res[0].last_result    = !end_v && !end_of_source;

    res[1].kind           = end_kind;
    res[1].out_byte       = 8'd0;
    res[1].error_code     = end_code;
    res[1].error_position = end_pos;
    res[1].last_result    = !end_of_source;

    res[2].kind           = cst_pkg::KIND_DONE;
    res[2].out_byte       = 8'd0;
    res[2].error_code     = cst_pkg::ERR_AFTER_QUOTE;
    res[2].error_position = 32'd0;
    res[2].last_result    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode     <= cst_pkg::QM_OUTSIDE;
      field_started  <= 1'b0;
      row_has_fields <= 1'b0;
      skip_next_lf   <= 1'b0;
      header_done    <= 1'b0;
      error_seen     <= 1'b0;
      byte_position  <= '0;
    end else if (advance) begin
      quote_mode     <= quote_mode_next;
      field_started  <= field_started_next;
      row_has_fields <= row_has_fields_next;
      skip_next_lf   <= skip_next_lf_next;
      header_done    <= header_done_next;
      error_seen     <= error_seen_next;
      byte_position  <= byte_position_next;
    end
  end

endmodule

// ===== hdl/cst_result_fifo.sv =====
// ----------------------------------------------------------------------------
// cst_result_fifo
// Small result queue: takes up to three results per cycle, gives one.
// ----------------------------------------------------------------------------
module cst_result_fifo (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        push,
  input  cst_pkg::result_t [cst_pkg::MAX_RESULTS-1:0] push_res,
  input  logic [cst_pkg::MAX_RESULTS-1:0]             push_valid,
  input  logic                                        pop,
  output cst_pkg::result_t                            head,
  output logic                                        not_empty,
  output logic                                        room,
  output logic [cst_pkg::CNT_BITS-1:0]                level
);

  cst_pkg::result_t entries [cst_pkg::FIFO_DEPTH];
  logic [cst_pkg::PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [cst_pkg::CNT_BITS-1:0] count, count_next, level_after_pop;
  logic [cst_pkg::PTR_BITS-1:0] offset [cst_pkg::MAX_RESULTS];
  logic [cst_pkg::CNT_BITS-1:0] npush;

  // compact the valid results into consecutive entries
  always_comb begin
    npush = '0;
    for (int k = 0; k < cst_pkg::MAX_RESULTS; k++) begin
      offset[k] = cst_pkg::PTR_BITS'(npush);
      npush     = npush + cst_pkg::CNT_BITS'(push_valid[k]);
    end
  end

  assign not_empty       = (count != '0);
  assign level_after_pop = count - cst_pkg::CNT_BITS'(pop);
  assign room            = level_after_pop <=
                           cst_pkg::CNT_BITS'(cst_pkg::FIFO_DEPTH - cst_pkg::MAX_RESULTS);
  assign count_next      = level_after_pop + (push ? npush : '0);
  assign head            = entries[rd_ptr];
  assign level           = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + cst_pkg::PTR_BITS'(npush);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < cst_pkg::MAX_RESULTS; k++) begin
      if (push && push_valid[k]) begin
        entries[cst_pkg::PTR_BITS'(wr_ptr + offset[k])] <= push_res[k];
      end
    end
  end

endmodule

// ===== hdl/csv_stream_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// csv_stream_tokenizer_top
// Streaming CSV tokenizer with APB configuration registers.
// ----------------------------------------------------------------------------
// throughput: one byte per cycle while each byte yields at most one result and out_ready stays high; a byte with
//   several results holds back later bytes while the single-result output drains the 4-entry result queue
// reset: synchronous, clears parse state and queue, loads register defaults; no clearing pass
module csv_stream_tokenizer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cst_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  input  logic                          end_of_source,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    kind,
  output logic [7:0]                    out_byte,
  output logic                          error_code,
  output logic [31:0]                   error_position,
  output logic                          last_result
);

  cst_pkg::cfg_t cfg;
  logic [1:0]    reg_index;
  logic          reg_write;

  logic          in_reg_valid;
  logic [7:0]    in_reg_byte;
  logic          in_reg_last;
  logic          advance;
  logic          room;
  logic          pop;

  cst_pkg::result_t [cst_pkg::MAX_RESULTS-1:0] res;
  logic [cst_pkg::MAX_RESULTS-1:0]             res_valid;
  cst_pkg::result_t                            head;
  logic [cst_pkg::CNT_BITS-1:0]                level;

  // configuration registers
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign reg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delimiter_char <= cst_pkg::DELIMITER_RESET;
      cfg.quote_char     <= cst_pkg::QUOTE_RESET;
      cfg.quote_enable   <= 1'b1;
      cfg.skip_first_row <= 1'b0;
    end else if (reg_write) begin
      unique case (reg_index)
        cst_pkg::REG_DELIMITER:   cfg.delimiter_char <= pwdata[7:0];
        cst_pkg::REG_QUOTE:       cfg.quote_char     <= pwdata[7:0];
        cst_pkg::REG_QUOTE_EN:    cfg.quote_enable   <= pwdata[0];
        cst_pkg::REG_SKIP_HEADER: cfg.skip_first_row <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      cst_pkg::REG_DELIMITER:   prdata = {24'd0, cfg.delimiter_char};
      cst_pkg::REG_QUOTE:       prdata = {24'd0, cfg.quote_char};
      cst_pkg::REG_QUOTE_EN:    prdata = {31'd0, cfg.quote_enable};
      cst_pkg::REG_SKIP_HEADER: prdata = {31'd0, cfg.skip_first_row};
    endcase
  end

  // input register; it moves on as soon as the queue can take three results
  assign advance  = in_reg_valid && room;
  assign in_ready = !in_reg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg_byte <= in_byte;
      in_reg_last <= end_of_source;
    end
  end

  cst_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .advance       (advance),
    .in_byte       (in_reg_byte),
    .end_of_source (in_reg_last),
    .res           (res),
    .res_valid     (res_valid)
  );

  assign pop = out_valid && out_ready;

  cst_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (advance),
    .push_res   (res),
    .push_valid (res_valid),
    .pop        (pop),
    .head       (head),
    .not_empty  (out_valid),
    .room       (room),
    .level      (level)
  );

  assign kind           = head.kind;
  assign out_byte       = head.out_byte;
  assign error_code     = head.error_code;
  assign error_position = head.error_position;
  assign last_result    = head.last_result;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= cst_pkg::CNT_BITS'(cst_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    advance && in_reg_last |-> res_valid[cst_pkg::MAX_RESULTS-1])
    else $error("last source byte without done result");

  a_in_reg_hold: assert property (@(posedge clk) disable iff (rst)
    in_reg_valid && !advance |=> in_reg_valid && $stable(in_reg_byte) && $stable(in_reg_last))
    else $error("held input byte lost or changed");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CSV stream tokenizer. Source texts are built
// from random rows of plain, quoted and empty fields with some noise mixed in,
// and are sent one byte per transfer across several delimiter and quote
// settings. A predictor tracks the parse state and queues the expected tokens,
// which the monitor compares field by field with each output transfer.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } src_byte_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [cst_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [7:0]                    in_byte = '0;
  logic                          end_of_source = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [2:0]                    kind;
  logic [7:0]                    out_byte;
  logic                          error_code;
  logic [31:0]                   error_position;
  logic                          last_result;

  csv_stream_tokenizer_top dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .end_of_source(end_of_source),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .out_byte(out_byte),
    .error_code(error_code),
    .error_position(error_position),
    .last_result(last_result)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // configuration and parse state as the predictor sees it
  logic [7:0]                        cfg_delim = cst_pkg::DELIMITER_RESET;
  logic [7:0]                        cfg_quote = cst_pkg::QUOTE_RESET;
  logic                              cfg_quote_en = 1'b1;
  logic                              cfg_skip_header = 1'b0;
  cst_pkg::quote_mode_t              qmode = cst_pkg::QM_OUTSIDE;
  logic                              field_open = 1'b0;
  logic                              row_has_fields = 1'b0;
  logic                              lf_pending = 1'b0;
  logic                              header_done = 1'b0;
  logic                              error_hold = 1'b0;
  logic [cst_pkg::POSITION_BITS-1:0] byte_pos = '0;

  cst_pkg::result_t step_tokens[$];
  cst_pkg::result_t expected_tokens[$];
  src_byte_t        source_bytes[$];

  int   error_count = 0;
  int   in_gap = 0;
  int   out_stall = 0;
  logic byte_taken = 1'b0;
  logic idling = 1'b1;

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    error_count++;
  endtask

  function automatic void emit_token(cst_pkg::kind_t k, logic [7:0] b, logic code,
                                     logic [31:0] p);
    cst_pkg::result_t r;
    if ((k == cst_pkg::KIND_CONTENT || k == cst_pkg::KIND_FIELD ||
         k == cst_pkg::KIND_ROW) && cfg_skip_header && !header_done)
      return;
    if (step_tokens.size() >= cst_pkg::MAX_RESULTS)
      return;
    r.kind = k;
    r.out_byte = b;
    r.error_code = code;
    r.error_position = p;
    r.last_result = 1'b0;
    step_tokens.insert(step_tokens.size(), r);
  endfunction

  function automatic void end_row();
    emit_token(cst_pkg::KIND_ROW, 8'h00, 1'b0, '0);
    header_done = 1'b1;
    field_open = 1'b0;
    row_has_fields = 1'b0;
    qmode = cst_pkg::QM_OUTSIDE;
  endfunction

  function automatic void outside_quotes(logic [7:0] b,
                                         logic [cst_pkg::POSITION_BITS-1:0] pos);
    if (cfg_quote_en && b == cfg_quote && !field_open) begin
      qmode = cst_pkg::QM_INSIDE;
      field_open = 1'b1;
    end else if (b == cfg_delim) begin
      emit_token(cst_pkg::KIND_FIELD, 8'h00, 1'b0, '0);
      field_open = 1'b0;
      row_has_fields = 1'b1;
      qmode = cst_pkg::QM_OUTSIDE;
    end else if (b == cst_pkg::CH_LF || b == cst_pkg::CH_CR) begin
      end_row();
      lf_pending = (b == cst_pkg::CH_CR);
    end else if (qmode == cst_pkg::QM_CLOSED) begin
      // only blanks may follow a closing quote
      if (!(b == cst_pkg::CH_SP || b == cst_pkg::CH_TAB || b == cst_pkg::CH_VT ||
            b == cst_pkg::CH_FF)) begin
        emit_token(cst_pkg::KIND_ERROR, 8'h00, cst_pkg::ERR_AFTER_QUOTE, 32'(pos));
        error_hold = 1'b1;
      end
    end else begin
      emit_token(cst_pkg::KIND_CONTENT, b, 1'b0, '0);
      field_open = 1'b1;
      qmode = cst_pkg::QM_OUTSIDE;
    end
  endfunction

  function automatic void tokenize_byte(logic [7:0] b, logic last);
    logic [cst_pkg::POSITION_BITS-1:0] pos;
    logic                              lf_swallowed;
    pos = byte_pos;
    byte_pos = pos + 1'b1;
    lf_swallowed = 1'b0;
    step_tokens.delete();
    if (!error_hold) begin
      if (lf_pending) begin
        lf_pending = 1'b0;
        lf_swallowed = (b == cst_pkg::CH_LF);
      end
      if (!lf_swallowed) begin
        if (qmode == cst_pkg::QM_INSIDE) begin
          if (b == cfg_quote)
            qmode = cst_pkg::QM_PENDING;
          else
            emit_token(cst_pkg::KIND_CONTENT, b, 1'b0, '0);
          field_open = 1'b1;
        end else if (qmode == cst_pkg::QM_PENDING && b == cfg_quote) begin
          // doubled quote
          emit_token(cst_pkg::KIND_CONTENT, b, 1'b0, '0);
          qmode = cst_pkg::QM_INSIDE;
        end else begin
          if (qmode == cst_pkg::QM_PENDING)
            qmode = cst_pkg::QM_CLOSED;
          outside_quotes(b, pos);
        end
      end
    end
    if (last) begin
      if (!error_hold) begin
        if (qmode == cst_pkg::QM_INSIDE)
          emit_token(cst_pkg::KIND_ERROR, 8'h00, cst_pkg::ERR_UNCLOSED, 32'(pos + 1'b1));
        else if (field_open || row_has_fields)
          end_row();
      end
      emit_token(cst_pkg::KIND_DONE, 8'h00, 1'b0, '0);
      qmode = cst_pkg::QM_OUTSIDE;
      field_open = 1'b0;
      row_has_fields = 1'b0;
      lf_pending = 1'b0;
      header_done = 1'b0;
      error_hold = 1'b0;
      byte_pos = '0;
    end
    if (step_tokens.size() > 0)
      step_tokens[step_tokens.size() - 1].last_result = 1'b1;
    foreach (step_tokens[i])
      expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
  endfunction

  // input side: prediction at the transfer, new byte at the falling edge
  always @(posedge clk) begin
    byte_taken = !rst && in_valid && in_ready;
    if (byte_taken) begin
      tokenize_byte(in_byte, end_of_source);
    end
  end

  always @(negedge clk) begin
    src_byte_t nxt;
    if (!rst && (!in_valid || byte_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (source_bytes.size() > 0) begin
        nxt = source_bytes.pop_front();
        in_valid <= 1'b1;
        in_byte <= nxt.data;
        end_of_source <= nxt.last;
        if (idling && $urandom_range(0, 5) == 0)
          in_gap = $urandom_range(1, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side
  always @(negedge clk) begin
    if (!rst) begin
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (idling && $urandom_range(0, 5) == 0)
          out_stall = $urandom_range(1, 4);
      end
    end
  end

  always @(posedge clk) begin
    cst_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch("token with none expected, kind", '0, 32'(kind));
      end else begin
        want = expected_tokens.pop_front();
        if (kind !== want.kind)
          report_mismatch("kind", 32'(want.kind), 32'(kind));
        if (out_byte !== want.out_byte)
          report_mismatch("out_byte", 32'(want.out_byte), 32'(out_byte));
        if (error_code !== want.error_code)
          report_mismatch("error_code", 32'(want.error_code), 32'(error_code));
        if (error_position !== want.error_position)
          report_mismatch("error_position", want.error_position, error_position);
        if (last_result !== want.last_result)
          report_mismatch("last_result", 32'(want.last_result), 32'(last_result));
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      cst_pkg::REG_DELIMITER:   cfg_delim = val[7:0];
      cst_pkg::REG_QUOTE:       cfg_quote = val[7:0];
      cst_pkg::REG_QUOTE_EN:    cfg_quote_en = val[0];
      cst_pkg::REG_SKIP_HEADER: cfg_skip_header = val[0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_reg(logic [1:0] idx, logic [31:0] want);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      report_mismatch("register readback", want, prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // nothing queued, nothing in flight, no tokens still expected, then a settling wait for byte-only work
  task automatic wait_idle();
    do @(posedge clk);
    while (source_bytes.size() != 0 || in_valid || expected_tokens.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic start_phase(logic [7:0] delim, logic [7:0] quote, logic quote_en,
                             logic skip_header, logic with_idling);
    wait_idle();
    write_reg(cst_pkg::REG_DELIMITER, {24'b0, delim});
    write_reg(cst_pkg::REG_QUOTE, {24'b0, quote});
    write_reg(cst_pkg::REG_QUOTE_EN, {31'b0, quote_en});
    write_reg(cst_pkg::REG_SKIP_HEADER, {31'b0, skip_header});
    check_reg(cst_pkg::REG_DELIMITER, {24'b0, delim});
    check_reg(cst_pkg::REG_QUOTE, {24'b0, quote});
    check_reg(cst_pkg::REG_QUOTE_EN, {31'b0, quote_en});
    check_reg(cst_pkg::REG_SKIP_HEADER, {31'b0, skip_header});
    idling = with_idling;
  endtask

  function automatic void push_byte(logic [7:0] b, logic last);
    src_byte_t s;
    s.data = b;
    s.last = last;
    source_bytes.insert(source_bytes.size(), s);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++)
      push_byte(s[i], 1'b0);
  endfunction

  function automatic logic [7:0] plain_byte(logic first);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == cfg_delim || b == cst_pkg::CH_CR || b == cst_pkg::CH_LF ||
           (first && b == cfg_quote));
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 3))
      0:       return cst_pkg::CH_SP;
      1:       return cst_pkg::CH_TAB;
      2:       return cst_pkg::CH_VT;
      default: return cst_pkg::CH_FF;
    endcase
  endfunction

  // one source text: rows of plain, quoted, empty and noisy fields
  function automatic void build_source();
    logic [7:0] text[$];
    int         rows;
    int         fields;
    int         len;
    rows = $urandom_range(1, 3);
    for (int r = 0; r < rows; r++) begin
      fields = $urandom_range(1, 4);
      for (int f = 0; f < fields; f++) begin
        if (f > 0)
          text.insert(text.size(), cfg_delim);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
              text.insert(text.size(), plain_byte(i == 0));
          end
          5, 6, 7: begin
            text.insert(text.size(), cfg_quote);
            len = $urandom_range(0, 5);
            for (int i = 0; i < len; i++) begin
              case ($urandom_range(0, 5))
                0: begin
                  text.insert(text.size(), cfg_quote);
                  text.insert(text.size(), cfg_quote);
                end
                1:       text.insert(text.size(), cfg_delim);
                2:       text.insert(text.size(), cst_pkg::CH_CR);
                3:       text.insert(text.size(), cst_pkg::CH_LF);
                default: text.insert(text.size(), plain_byte(1'b1));
              endcase
            end
            text.insert(text.size(), cfg_quote);
            repeat ($urandom_range(0, 2)) text.insert(text.size(), blank_byte());
            if ($urandom_range(0, 9) == 0)
              text.insert(text.size(), plain_byte(1'b1));
          end
          8: ;
          default: begin
            repeat ($urandom_range(1, 3))
              text.insert(text.size(), 8'($urandom_range(0, 255)));
          end
        endcase
      end
      if (r < rows - 1 || $urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 2))
          0: text.insert(text.size(), cst_pkg::CH_LF);
          1: text.insert(text.size(), cst_pkg::CH_CR);
          default: begin
            text.insert(text.size(), cst_pkg::CH_CR);
            text.insert(text.size(), cst_pkg::CH_LF);
          end
        endcase
      end
    end
    // now and then leave a quoted field open at the end
    if ($urandom_range(0, 11) == 0) begin
      text.insert(text.size(), cfg_quote);
      text.insert(text.size(), plain_byte(1'b1));
    end
    if (text.size() == 0)
      text.insert(text.size(), plain_byte(1'b1));
    foreach (text[i])
      push_byte(text[i], i == text.size() - 1);
  endfunction

  function automatic void add_sources(int count);
    int target;
    target = source_bytes.size() + count;
    while (source_bytes.size() < target)
      build_source();
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    start_phase(cst_pkg::DELIMITER_RESET, cst_pkg::QUOTE_RESET, 1'b1, 1'b0, 1'b1);
    // doubled quote, blanks after a closing quote, CRLF
    push_text("a,\"b\"\"c\" ,");
    push_byte(cst_pkg::CH_CR, 1'b0);
    push_byte(cst_pkg::CH_LF, 1'b0);
    // stray byte after a closing quote, then silence until the last byte
    push_text("\"q\"x");
    push_byte(8'hFF, 1'b1);
    // quoted field still open at the end
    push_text("\"ab");
    push_byte(cst_pkg::CH_LF, 1'b1);
    // lone byte: content, row end and done together
    push_byte(8'h00, 1'b1);
    // quote pending on the last byte closes the field
    push_text("\"z");
    push_byte(cst_pkg::QUOTE_RESET, 1'b1);
    add_sources(70);

    start_phase(8'h3B, 8'h27, 1'b1, 1'b1, 1'b1);
    add_sources(80);

    // delimiter equal to CR acts as a delimiter
    start_phase(cst_pkg::CH_CR, 8'h00, 1'b1, 1'b0, 1'b1);
    push_text("a");
    push_byte(cst_pkg::CH_CR, 1'b0);
    push_byte(cst_pkg::CH_LF, 1'b1);
    add_sources(75);

    start_phase(8'h00, 8'hFF, 1'b0, 1'b1, 1'b1);
    add_sources(70);

    start_phase(8'hFF, 8'h00, 1'b1, 1'b0, 1'b1);
    add_sources(70);

    start_phase(cst_pkg::CH_LF, cst_pkg::QUOTE_RESET, 1'b1, 1'b1, 1'b1);
    add_sources(70);

    // closing stretch at full rate on both sides
    start_phase(cst_pkg::DELIMITER_RESET, cst_pkg::QUOTE_RESET, 1'b1, 1'b0, 1'b0);
    add_sources(60);

    wait_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
